>>> sv/png_scanline_unfilter_macros.svh
// ----------------------------------------------------------------------------
// PNG scanline unfilter: assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication
`define PNGU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNGU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared constants, codes and stage types of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pngu_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ADDR_W   = $clog2(MAX_ROW_BYTES);
  localparam int POS_W    = $clog2(MAX_ROW_BYTES + 1);
  localparam int PBI_W    = $clog2(MAX_PIXEL_BYTES);
  localparam int RB_CFG_W = 14;
  localparam int PB_CFG_W = 4;
  localparam int ROWS_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd2;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_FILTER = 2'd1;
  localparam logic [1:0] ERR_ROWS   = 2'd2;

  // item waiting for its line store read
  typedef struct packed {
    logic [7:0]        byte_value;
    logic [2:0]        filter;
    logic              have_left;
    logic              have_up;
    logic [PBI_W-1:0]  pb_idx;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              eoi;
    logic [1:0]        err;
  } pngu_s1_t;

endpackage

>>> sv/pngu_line_ram.sv
// ----------------------------------------------------------------------------
// pngu_line_ram
// Previous-row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pngu_line_ram
  import pngu_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [MAX_ROW_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/pngu_ctrl.sv
// ----------------------------------------------------------------------------
// pngu_ctrl
// Configuration registers, row/byte sequencing, error latch and the first
// pipeline stage that issues the line store read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pngu_ctrl
  import pngu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_byte,
  input  logic                 in_sof,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr,
  output logic                 s1_valid,
  output pngu_s1_t             s1,
  input  logic                 s1_ready
);

  logic [RB_CFG_W-1:0] row_bytes_r;
  logic [PB_CFG_W-1:0] pixel_bytes_r;
  logic [ROWS_W-1:0]   image_rows_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  logic [2:0]        filt_r, filt_nxt;
  logic [1:0]        err_r, err_nxt;
  logic              s1_v_r, s1_v_nxt;
  pngu_s1_t          s1_r, s1_nxt;

  logic [POS_W-1:0]  rb;
  logic [PBI_W-1:0]  pbi;
  logic              acc;
  logic [POS_W-1:0]  pos_eff, p;
  logic [ROWS_W-1:0] row_eff, row_inc;
  logic [1:0]        err_eff;
  logic              is_hdr, emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r   <= RB_CFG_W'(2);
      pixel_bytes_r <= PB_CFG_W'(1);
      image_rows_r  <= ROWS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_BYTES:   row_bytes_r   <= cfg_wdata[RB_CFG_W-1:0];
        CFG_PIXEL_BYTES: pixel_bytes_r <= cfg_wdata[PB_CFG_W-1:0];
        CFG_IMAGE_ROWS:  image_rows_r  <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated geometry
  always_comb begin
    if (32'(row_bytes_r) > 32'(MAX_ROW_BYTES)) begin
      rb = POS_W'(MAX_ROW_BYTES);
    end else if (row_bytes_r == '0) begin
      rb = POS_W'(1);
    end else begin
      rb = POS_W'(row_bytes_r);
    end
    if (32'(pixel_bytes_r) > 32'(MAX_PIXEL_BYTES)) begin
      pbi = PBI_W'(MAX_PIXEL_BYTES - 1);
    end else if (pixel_bytes_r == '0) begin
      pbi = '0;
    end else begin
      pbi = PBI_W'(pixel_bytes_r - PB_CFG_W'(1));
    end
  end

  assign in_tready = !s1_v_r || s1_ready;
  assign acc       = in_tvalid && in_tready;

  assign pos_eff = in_sof ? '0 : pos_r;
  assign row_eff = in_sof ? '0 : row_r;
  assign err_eff = in_sof ? ERR_OK : err_r;
  assign is_hdr  = (pos_eff == '0) || (pos_eff > rb);
  assign p       = pos_eff - POS_W'(1);
  assign row_inc = row_eff + ROWS_W'(1);

  always_comb begin
    pos_nxt  = pos_r;
    row_nxt  = row_r;
    filt_nxt = filt_r;
    err_nxt  = err_r;
    emit     = 1'b0;
    s1_nxt   = '0;
    s1_nxt.byte_value = in_byte;
    s1_nxt.filter     = filt_r;
    s1_nxt.pb_idx     = pbi;
    s1_nxt.addr       = p[ADDR_W-1:0];
    if (acc) begin
      pos_nxt = pos_eff;
      row_nxt = row_eff;
      err_nxt = err_eff;
      if (err_eff != ERR_OK) begin
        emit       = 1'b1;
        s1_nxt.err = err_eff;
      end else if (is_hdr) begin
        if (row_eff >= image_rows_r) begin
          emit       = 1'b1;
          err_nxt    = ERR_ROWS;
          s1_nxt.err = ERR_ROWS;
        end else if (in_byte > 8'(FLT_PAETH)) begin
          emit       = 1'b1;
          err_nxt    = ERR_FILTER;
          s1_nxt.err = ERR_FILTER;
        end else begin
          filt_nxt = in_byte[2:0];
          pos_nxt  = POS_W'(1);
        end
      end else begin
        emit             = 1'b1;
        s1_nxt.have_left = p > POS_W'(pbi);
        s1_nxt.have_up   = row_eff != '0;
        if (pos_eff >= rb) begin
          s1_nxt.last = 1'b1;
          s1_nxt.eoi  = row_inc == image_rows_r;
          pos_nxt     = '0;
          row_nxt     = row_inc;
        end else begin
          pos_nxt = pos_eff + POS_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (acc) begin
      s1_v_nxt = emit;
    end else if (s1_ready) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      row_r  <= '0;
      filt_r <= FLT_NONE;
      err_r  <= ERR_OK;
      s1_v_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      row_r  <= row_nxt;
      filt_r <= filt_nxt;
      err_r  <= err_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

  assign rd_en    = acc;
  assign rd_addr  = p[ADDR_W-1:0];
  assign s1_valid = s1_v_r;
  assign s1       = s1_r;

endmodule

>>> sv/pngu_recon.sv
// ----------------------------------------------------------------------------
// pngu_recon
// Second stage: neighbor windows, filter predictor, line store write-back
// and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pngu_recon
  import pngu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  pngu_s1_t          s1,
  output logic              s1_ready,
  input  logic [7:0]        up_byte,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_pixel,
  output logic              out_eor,
  output logic              out_eoi,
  output logic [1:0]        out_err
);

  logic [7:0] left_win_r [MAX_PIXEL_BYTES];
  logic [7:0] ul_win_r   [MAX_PIXEL_BYTES];
  logic       out_v_r;
  logic [7:0] pix_r;
  logic       eor_r, eoi_r;
  logic [1:0] err_r;

  logic        adv, ok;
  logic [7:0]  a, b, c, pred, res;
  logic [8:0]  sum_ab;
  logic signed [9:0] d_pa, d_pb, d_pc;
  logic [9:0]  pa, pb, pc;

  function automatic logic [9:0] abs10(input logic signed [9:0] x);
    return x[9] ? 10'(-x) : 10'(x);
  endfunction

  assign s1_ready = !out_v_r || out_tready;
  assign adv      = s1_valid && s1_ready;
  assign ok       = s1.err == ERR_OK;

  assign b = s1.have_up ? up_byte : 8'd0;
  assign a = s1.have_left ? left_win_r[s1.pb_idx] : 8'd0;
  assign c = (s1.have_left && s1.have_up) ? ul_win_r[s1.pb_idx] : 8'd0;

  // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
  assign sum_ab = {1'b0, a} + {1'b0, b};
  assign d_pa   = $signed({2'b00, b}) - $signed({2'b00, c});
  assign d_pb   = $signed({2'b00, a}) - $signed({2'b00, c});
  assign d_pc   = $signed({1'b0, sum_ab}) - $signed({1'b0, c, 1'b0});
  assign pa     = abs10(d_pa);
  assign pb     = abs10(d_pb);
  assign pc     = abs10(d_pc);

  always_comb begin
    case (s1.filter)
      FLT_SUB: pred = a;
      FLT_UP:  pred = b;
      FLT_AVG: pred = sum_ab[8:1];
      FLT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: pred = 8'd0;
    endcase
  end

  assign res = s1.byte_value + pred;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_win_r[i] <= 8'd0;
        ul_win_r[i]   <= 8'd0;
      end
    end else if (adv && ok) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_win_r[i] <= left_win_r[i-1];
        ul_win_r[i]   <= ul_win_r[i-1];
      end
      left_win_r[0] <= res;
      ul_win_r[0]   <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r <= ok ? res : 8'd0;
      eor_r <= ok && s1.last;
      eoi_r <= ok && s1.eoi;
      err_r <= s1.err;
    end
  end

  assign wr_en      = adv && ok;
  assign wr_addr    = s1.addr;
  assign wr_data    = res;
  assign out_tvalid = out_v_r;
  assign out_pixel  = pix_r;
  assign out_eor    = eor_r;
  assign out_eoi    = eoi_r;
  assign out_err    = err_r;

endmodule

>>> sv/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG row reconstruction (None/Sub/Up/Average/Paeth) over an inflated byte
// stream, previous row held in a single-port-write line store.
//
//   channel  dir  tdata (low bit up)   tlast       tuser (low bit up)
//   in_      in   byte_value[7:0]      -           start_of_image
//   out_     out  pixel_byte[7:0]      end_of_row  end_of_image, error_code[1:0]
//   cfg_     in   index 0 row_bytes, 1 pixel_bytes, 2 image_rows
//
// One item per cycle while in_tready is high; a result passes the stage and
// output registers. Filter bytes give a result only on error. The line store
// is read at accept; its registered data reaches the reconstruct stage in the
// next cycle. Reset is synchronous; the line store is not cleared. in_tready
// drops only while the stage and output registers both hold a waiting item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter
  import pngu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // byte_value
  input  logic [0:0]           in_tuser,   // start_of_image
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // pixel_byte
  output logic                 out_tlast,  // end_of_row
  output logic [2:0]           out_tuser   // end_of_image, error_code[1:0]
);

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              s1_valid, s1_ready;
  pngu_s1_t          s1;
  logic              eoi;
  logic [1:0]        err;

  pngu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_sof    (in_tuser[0]),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_ready  (s1_ready)
  );

  pngu_line_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pngu_recon u_recon (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_ready   (s1_ready),
    .up_byte    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pixel  (out_tdata),
    .out_eor    (out_tlast),
    .out_eoi    (eoi),
    .out_err    (err)
  );

  assign out_tuser = {err, eoi};

  `PNGU_ASSERT_IMP(a_err_zero_payload,
    out_tvalid && (out_tuser[2:1] != ERR_OK),
    (out_tdata == 8'd0) && !out_tlast && !out_tuser[0],
    "error item carries nonzero payload")
  `PNGU_ASSERT_IMP(a_eoi_has_eor, out_tvalid && out_tuser[0], out_tlast,
    "end of image without end of row")
  `PNGU_ASSERT_IMP(a_stall_only_on_output, !in_tready, out_tvalid && !out_tready,
    "input stalled while output is free")
  `PNGU_ASSERT_NXT(a_no_write_after_error,
    out_tvalid && out_tready && (out_tuser[2:1] != ERR_OK) && !in_tvalid && !s1_valid,
    !wr_en,
    "line store written with no item in flight")

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: PNG scanline unfilter testbench
// Streams filter and data bytes into png_scanline_unfilter under random idle
// and stall on both sides. A built-in unfilter model (None/Sub/Up/Average/
// Paeth, line store, sticky errors) predicts the results that the directed
// table does not give; all are compared field by field. The table runs first,
// then random images over several register settings, including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pngu_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;
  localparam int WIDE_ITEMS    = 120;
  localparam int RANDOM_ITEMS  = 400;

  typedef struct packed {
    logic [7:0] pix;
    logic       eor;
    logic       eoi;
    logic [1:0] err;
  } pix_result_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} stim_kind_t;

  typedef struct packed {
    stim_kind_t           kind;
    logic [7:0]           value;
    logic                 soi;
    logic                 typed;
    pix_result_t          res;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     wdata;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // byte_value
  logic [0:0]           in_tuser = '0;   // start_of_image
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // pixel_byte
  logic                 out_tlast;       // end_of_row
  logic [2:0]           out_tuser;       // end_of_image, error_code[1:0]

  png_scanline_unfilter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // unfilter model state
  logic [RB_CFG_W-1:0] cfg_row_bytes = 14'd2;
  logic [PB_CFG_W-1:0] cfg_pixel_bytes = 4'd1;
  logic [ROWS_W-1:0]   cfg_image_rows = 16'd1;
  logic [7:0]          line_mem [MAX_ROW_BYTES];
  logic [MAX_PIXEL_BYTES-1:0][7:0] left_win = '0;
  logic [MAX_PIXEL_BYTES-1:0][7:0] upleft_win = '0;
  logic [2:0]          cur_filter = FLT_NONE;
  int unsigned         byte_pos = 0;
  logic [ROWS_W-1:0]   rows_done = '0;
  bit                  err_sticky = 1'b0;
  logic [1:0]          err_kind = ERR_OK;

  pix_result_t pixel_q [$];
  stim_row_t   directed_rows [$];

  int n_items = 0;
  int n_results = 0;
  int n_err_results = 0;
  int n_fail = 0;
  int n_settings = 0;
  int idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_cnt = 0;
  int rx_gap = 0;
  pix_result_t rx_want;

  function automatic int eff_row_bytes();
    int rb;
    rb = int'(cfg_row_bytes);
    if (rb < 1) rb = 1;
    if (rb > MAX_ROW_BYTES) rb = MAX_ROW_BYTES;
    return rb;
  endfunction

  function automatic bit unfilter_step(input logic [7:0] v, input logic soi,
                                       output pix_result_t r);
    int unsigned rb, pb, p;
    int a, b, c, est, da, db, dc;
    logic [7:0] pred, pix;
    bit hl, hu;
    rb = eff_row_bytes();
    pb = int'(cfg_pixel_bytes);
    if (pb < 1) pb = 1;
    if (pb > MAX_PIXEL_BYTES) pb = MAX_PIXEL_BYTES;
    r = '0;
    if (soi) begin
      rows_done = '0;
      byte_pos = 0;
      err_sticky = 1'b0;
      err_kind = ERR_OK;
    end
    if (err_sticky) begin
      r.err = err_kind;
      return 1'b1;
    end
    if (byte_pos == 0 || byte_pos > rb) begin
      if (rows_done >= cfg_image_rows) begin
        err_sticky = 1'b1;
        err_kind = ERR_ROWS;
        r.err = ERR_ROWS;
        return 1'b1;
      end
      if (v > 8'd4) begin
        err_sticky = 1'b1;
        err_kind = ERR_FILTER;
        r.err = ERR_FILTER;
        return 1'b1;
      end
      cur_filter = v[2:0];
      byte_pos = 1;
      left_win = '0;
      upleft_win = '0;
      return 1'b0;
    end
    p = byte_pos - 1;
    hl = (p >= pb);
    hu = (rows_done != 0);
    a = hl ? int'(left_win[pb-1]) : 0;
    b = hu ? int'(line_mem[p]) : 0;
    c = (hl && hu) ? int'(upleft_win[pb-1]) : 0;
    case (cur_filter)
      FLT_SUB: pred = 8'(a);
      FLT_UP: pred = 8'(b);
      FLT_AVG: pred = 8'((a + b) >> 1);
      FLT_PAETH: begin
        est = a + b - c;
        da = (est > a) ? est - a : a - est;
        db = (est > b) ? est - b : b - est;
        dc = (est > c) ? est - c : c - est;
        if (da <= db && da <= dc) pred = 8'(a);
        else if (db <= dc) pred = 8'(b);
        else pred = 8'(c);
      end
      default: pred = 8'd0;
    endcase
    pix = v + pred;
    upleft_win = {upleft_win[MAX_PIXEL_BYTES-2:0], 8'(b)};
    left_win = {left_win[MAX_PIXEL_BYTES-2:0], pix};
    line_mem[p] = pix;
    r.pix = pix;
    if (p + 1 >= rb) begin
      byte_pos = 0;
      rows_done = rows_done + 1'b1;
      r.eor = 1'b1;
      r.eoi = (rows_done == cfg_image_rows);
    end else begin
      byte_pos = byte_pos + 1;
    end
    return 1'b1;
  endfunction

  // result side: random stalls, a long hold on each request, field checks
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tuser[2:1] != ERR_OK) n_err_results++;
      if (pixel_q.size() == 0) begin
        $error("unexpected result item: pixel_byte %0h", out_tdata);
        n_fail++;
      end else begin
        rx_want = pixel_q.pop_front();
        if (out_tdata !== rx_want.pix) begin
          $error("pixel_byte: expected %0h, got %0h", rx_want.pix, out_tdata);
          n_fail++;
        end
        if (out_tlast !== rx_want.eor) begin
          $error("end_of_row: expected %0d, got %0d", rx_want.eor, out_tlast);
          n_fail++;
        end
        if (out_tuser[0] !== rx_want.eoi) begin
          $error("end_of_image: expected %0d, got %0d", rx_want.eoi, out_tuser[0]);
          n_fail++;
        end
        if (out_tuser[2:1] !== rx_want.err) begin
          $error("error_code: expected %0d, got %0d", rx_want.err, out_tuser[2:1]);
          n_fail++;
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      rx_gap <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic put_byte(input logic [7:0] v, input logic soi, input logic typed,
                          input pix_result_t typed_res);
    pix_result_t r;
    bit has;
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 16);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tuser <= soi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = unfilter_step(v, soi, r);
    if (typed) pixel_q.push_back(typed_res);
    else if (has) pixel_q.push_back(r);
    n_items++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ROW_BYTES: cfg_row_bytes = val[RB_CFG_W-1:0];
      CFG_PIXEL_BYTES: cfg_pixel_bytes = val[PB_CFG_W-1:0];
      CFG_IMAGE_ROWS: cfg_image_rows = val[ROWS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] pb,
                                input logic [CFG_W-1:0] rows);
    settle();
    cfg_write(CFG_ROW_BYTES, rb);
    cfg_write(CFG_PIXEL_BYTES, pb);
    cfg_write(CFG_IMAGE_ROWS, rows);
    n_settings++;
  endtask

  // one image; noisy images may carry a bad filter, a cut row, trailing bytes
  // or stray start markers
  task automatic send_image(input int n_rows, input bit noisy);
    int rb, kind, cut_row, cut_at;
    rb = eff_row_bytes();
    kind = noisy ? $urandom_range(0, 9) : 0;
    cut_row = $urandom_range(0, n_rows - 1);
    cut_at = $urandom_range(0, rb - 1);
    for (int r = 0; r < n_rows; r++) begin
      if (kind == 1 && r == cut_row)
        put_byte(8'($urandom_range(5, 255)), r == 0, 1'b0, '0);
      else
        put_byte(8'($urandom_range(0, 4)), r == 0, 1'b0, '0);
      for (int k = 0; k < rb; k++) begin
        if (kind == 2 && r == cut_row && k == cut_at) return;
        put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
    end
    if (kind == 3)
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    if (kind == 4)
      repeat ($urandom_range(1, 6))
        put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  function automatic void add_byte(input logic [7:0] v, input logic soi);
    stim_row_t s;
    s = '0;
    s.kind = ROW_BYTE;
    s.value = v;
    s.soi = soi;
    directed_rows.push_back(s);
  endfunction

  function automatic void add_checked(input logic [7:0] v, input logic soi, input logic [7:0] pix,
                                     input logic eor, input logic eoi, input logic [1:0] err);
    stim_row_t s;
    s = '0;
    s.kind = ROW_BYTE;
    s.value = v;
    s.soi = soi;
    s.typed = 1'b1;
    s.res = '{pix: pix, eor: eor, eoi: eoi, err: err};
    directed_rows.push_back(s);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    stim_row_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.idx = idx;
    s.wdata = val;
    directed_rows.push_back(s);
  endfunction

  initial begin
    int rand_base, pb_pick, rows_pick;
    bit first_random;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 2 bytes per row, 1 byte per pixel, 1 row
    add_byte({5'd0, FLT_NONE}, 1'b1);
    add_checked(8'h00, 1'b0, 8'h00, 1'b0, 1'b0, ERR_OK);
    add_checked(8'hFF, 1'b0, 8'hFF, 1'b1, 1'b1, ERR_OK);
    add_checked(8'h02, 1'b0, 8'h00, 1'b0, 1'b0, ERR_ROWS);    // row past the last
    add_checked(8'h55, 1'b0, 8'h00, 1'b0, 1'b0, ERR_ROWS);    // sticky
    add_checked(8'h05, 1'b1, 8'h00, 1'b0, 1'b0, ERR_FILTER);  // bad filter type
    add_checked(8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, ERR_FILTER);
    add_checked(8'hFF, 1'b1, 8'h00, 1'b0, 1'b0, ERR_FILTER);
    add_cfg(CFG_ROW_BYTES, 16'd3);
    add_cfg(CFG_IMAGE_ROWS, 16'd4);
    add_byte({5'd0, FLT_SUB}, 1'b1);
    add_byte(8'h10, 1'b0);
    add_byte(8'hF5, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte({5'd0, FLT_UP}, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte({5'd0, FLT_AVG}, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'h33, 1'b0);
    add_byte({5'd0, FLT_PAETH}, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h00, 1'b0);

    idle_pct <= 20;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        put_byte(directed_rows[i].value, directed_rows[i].soi, directed_rows[i].typed,
                 directed_rows[i].res);
      end
    end

    // out-of-range registers saturate: 1 byte rows, 1 byte pixels
    apply_settings(16'd0, 16'd0, 16'd1);
    repeat (4) send_image(1, 1'b1);

    // widest rows and pixels, start of the first row, with a long output stall
    idle_pct <= 5;
    apply_settings(16'd16383, 16'd15, 16'd2);
    hold_req <= hold_req + 1;
    put_byte(8'($urandom_range(0, 4)), 1'b1, 1'b0, '0);
    repeat (WIDE_ITEMS) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);

    idle_pct <= 10;
    apply_settings(16'd20, 16'd8, 16'd65535);
    repeat (2) send_image(4, 1'b1);

    // no rows allowed at all
    apply_settings(16'd6, 16'd3, 16'd0);
    repeat (2) send_image(1, 1'b1);

    rand_base = n_items;
    first_random = 1'b1;
    while (n_items - rand_base < RANDOM_ITEMS) begin
      if (n_items - rand_base >= RANDOM_ITEMS - 100) idle_pct <= 0;
      else idle_pct <= ($urandom_range(0, 2) == 0) ? 0 : ($urandom_range(0, 1) ? 10 : 25);
      pb_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      rows_pick = $urandom_range(1, 5);
      apply_settings(16'($urandom_range(2, 24)), 16'(pb_pick), 16'(rows_pick));
      if (first_random) begin
        hold_req <= hold_req + 1;
        first_random = 1'b0;
      end
      repeat ($urandom_range(1, 3)) send_image($urandom_range(1, rows_pick), 1'b1);
    end

    settle();
    $display("Run covered %0d input items over %0d register settings,", n_items, n_settings);
    $display("%0d result items checked, %0d of them error results.", n_results, n_err_results);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
